// ----- rtl/aftb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package aftb_pkg;

   localparam int LTE_ROWS = 63;

   localparam logic [1:0] CMD_LTE     = 2'd0;
   localparam logic [1:0] CMD_NR      = 2'd1;
   localparam logic [1:0] CMD_WCDMA   = 2'd2;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   localparam logic [21:0] NR_LAST_LOW  = 22'd599999;
   localparam logic [21:0] NR_LAST_MID  = 22'd2016666;
   localparam logic [21:0] NR_LAST_HIGH = 22'd3279165;
   localparam logic [21:0] NR_FIRST_MID  = 22'd600000;
   localparam logic [21:0] NR_FIRST_HIGH = 22'd2016667;
   localparam logic [29:0] NR_BASE_MID  = 30'd3000000;
   localparam logic [29:0] NR_BASE_HIGH = 30'd24250080;

   localparam logic [7:0] STEP_LTE     = 8'd100;
   localparam logic [7:0] STEP_NR_LOW  = 8'd5;
   localparam logic [7:0] STEP_NR_MID  = 8'd15;
   localparam logic [7:0] STEP_NR_HIGH = 8'd60;
   localparam logic [7:0] STEP_WCDMA   = 8'd200;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [21:0] channel_number;
   } req_type;

   typedef struct packed {
      logic [29:0] carrier_khz;
      logic [6:0]  band_number;
      logic        converted;
   } rsp_type;

   typedef struct packed {
      logic [16:0] lo;
      logic [16:0] hi;
      logic [22:0] edge_khz;
      logic [6:0]  band;
   } lte_row_type;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [21:0]         channel_number;
      logic [LTE_ROWS-1:0] hit;
   } match_type;

   typedef struct packed {
      logic [21:0] offset;
      logic [7:0]  step;
      logic [29:0] base;
      logic [6:0]  band;
      logic        ok;
   } sel_type;

   localparam lte_row_type LTE_TAB [LTE_ROWS] = '{
      '{17'd0,     17'd599,   23'd2110000, 7'd1},
      '{17'd600,   17'd1199,  23'd1930000, 7'd2},
      '{17'd1200,  17'd1949,  23'd1805000, 7'd3},
      '{17'd1950,  17'd2399,  23'd2110000, 7'd4},
      '{17'd2400,  17'd2649,  23'd869000,  7'd5},
      '{17'd2650,  17'd2749,  23'd875000,  7'd6},
      '{17'd2750,  17'd3449,  23'd2620000, 7'd7},
      '{17'd3450,  17'd3799,  23'd925000,  7'd8},
      '{17'd3800,  17'd4149,  23'd1844900, 7'd9},
      '{17'd4150,  17'd4749,  23'd2110000, 7'd10},
      '{17'd4750,  17'd4949,  23'd1475900, 7'd11},
      '{17'd5010,  17'd5179,  23'd729000,  7'd12},
      '{17'd5180,  17'd5279,  23'd746000,  7'd13},
      '{17'd5280,  17'd5379,  23'd758000,  7'd14},
      '{17'd5730,  17'd5849,  23'd860000,  7'd17},
      '{17'd5850,  17'd5999,  23'd875000,  7'd18},
      '{17'd6000,  17'd6149,  23'd890000,  7'd19},
      '{17'd6150,  17'd6449,  23'd791000,  7'd20},
      '{17'd6450,  17'd6599,  23'd1495900, 7'd21},
      '{17'd6600,  17'd7399,  23'd3510000, 7'd22},
      '{17'd7500,  17'd7699,  23'd1525000, 7'd24},
      '{17'd7700,  17'd8039,  23'd1930000, 7'd25},
      '{17'd8040,  17'd8689,  23'd859000,  7'd26},
      '{17'd8690,  17'd9039,  23'd852000,  7'd27},
      '{17'd9040,  17'd9209,  23'd758000,  7'd28},
      '{17'd9210,  17'd9659,  23'd717000,  7'd29},
      '{17'd9660,  17'd9769,  23'd2350000, 7'd30},
      '{17'd9770,  17'd9869,  23'd462500,  7'd31},
      '{17'd9870,  17'd10359, 23'd1452000, 7'd32},
      '{17'd36000, 17'd36199, 23'd1900000, 7'd33},
      '{17'd36200, 17'd36349, 23'd2010000, 7'd34},
      '{17'd36350, 17'd36949, 23'd1850000, 7'd35},
      '{17'd36950, 17'd37549, 23'd1930000, 7'd36},
      '{17'd37550, 17'd37749, 23'd1910000, 7'd37},
      '{17'd37750, 17'd38249, 23'd2570000, 7'd38},
      '{17'd38250, 17'd38649, 23'd1880000, 7'd39},
      '{17'd38650, 17'd39649, 23'd2300000, 7'd40},
      '{17'd39650, 17'd41589, 23'd2496000, 7'd41},
      '{17'd41590, 17'd43589, 23'd3400000, 7'd42},
      '{17'd43590, 17'd45589, 23'd3600000, 7'd43},
      '{17'd45590, 17'd46589, 23'd703000,  7'd44},
      '{17'd46590, 17'd46789, 23'd1447000, 7'd45},
      '{17'd46790, 17'd54539, 23'd5150000, 7'd46},
      '{17'd54540, 17'd55239, 23'd5855000, 7'd47},
      '{17'd55240, 17'd56739, 23'd3550000, 7'd48},
      '{17'd56740, 17'd58239, 23'd3550000, 7'd49},
      '{17'd58240, 17'd59089, 23'd1432000, 7'd50},
      '{17'd59090, 17'd59139, 23'd1427000, 7'd51},
      '{17'd59140, 17'd60139, 23'd3300000, 7'd52},
      '{17'd60140, 17'd60254, 23'd2483500, 7'd53},
      '{17'd65536, 17'd66435, 23'd2110000, 7'd65},
      '{17'd66436, 17'd67335, 23'd2110000, 7'd66},
      '{17'd67336, 17'd67535, 23'd738000,  7'd67},
      '{17'd67536, 17'd67835, 23'd753000,  7'd68},
      '{17'd67836, 17'd68335, 23'd2570000, 7'd69},
      '{17'd68336, 17'd68585, 23'd1995000, 7'd70},
      '{17'd68586, 17'd68935, 23'd617000,  7'd71},
      '{17'd68936, 17'd68985, 23'd461000,  7'd72},
      '{17'd68986, 17'd69035, 23'd460000,  7'd73},
      '{17'd69036, 17'd69465, 23'd1475000, 7'd74},
      '{17'd69466, 17'd70315, 23'd1432000, 7'd75},
      '{17'd70316, 17'd70365, 23'd1427000, 7'd76},
      '{17'd70366, 17'd70545, 23'd728000,  7'd85}
   };

endpackage

`default_nettype wire

// ----- rtl/arfcn_to_frequency_and_band.sv -----
// Requests pass through four register stages to rsp_valid; a low rsp_ready stalls them.
// Throughput: one transaction per cycle when not stalled; the stages (band range compare,
// row select and offset, constant-step multiply, base add) each take a new item every cycle.
// Reset: synchronous, active high; clears all stage valid bits, payload registers hold.
`timescale 1ns / 1ps
`default_nettype none

module arfcn_to_frequency_and_band (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire aftb_pkg::req_type  req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output aftb_pkg::rsp_type       rsp_payload
);
   import aftb_pkg::*;

   logic      match_valid;
   logic      match_ready;
   match_type match_data;
   logic      sel_valid;
   logic      sel_ready;
   sel_type   sel_data;

   aftb_match u_match (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_payload),
      .out_valid (match_valid),
      .out_ready (match_ready),
      .out_data  (match_data)
   );

   aftb_select u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (match_valid),
      .in_ready  (match_ready),
      .in_data   (match_data),
      .out_valid (sel_valid),
      .out_ready (sel_ready),
      .out_data  (sel_data)
   );

   aftb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sel_valid),
      .in_ready  (sel_ready),
      .in_data   (sel_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_payload)
   );

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.converted |->
         rsp_payload.carrier_khz == 30'd0 && rsp_payload.band_number == 7'd0)
      else $error("unconverted transaction carries frequency or band");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.band_number != 7'd0 |-> rsp_payload.converted)
      else $error("band reported without conversion");

   assert property (@(posedge clock) disable iff (reset)
      sel_valid && !sel_data.ok |-> sel_data.offset == 22'd0 && sel_data.base == 30'd0)
      else $error("selected row without match carries offset or base");

endmodule

`default_nettype wire

// ----- rtl/aftb_match.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aftb_match (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire aftb_pkg::req_type  in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output aftb_pkg::match_type     out_data
);
   import aftb_pkg::*;

   logic      valid_ff;
   match_type data_ff;
   match_type data_in;

   always_comb begin
      data_in.cmd            = in_data.cmd;
      data_in.channel_number = in_data.channel_number;
      for (int i = 0; i < LTE_ROWS; i++) begin
         data_in.hit[i] = (in_data.cmd == CMD_LTE) &&
                          (in_data.channel_number >= {5'b0, LTE_TAB[i].lo}) &&
                          (in_data.channel_number <= {5'b0, LTE_TAB[i].hi});
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/aftb_select.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aftb_select (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire aftb_pkg::match_type  in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output aftb_pkg::sel_type         out_data
);
   import aftb_pkg::*;

   logic        valid_ff;
   sel_type     data_ff;
   sel_type     data_in;
   lte_row_type row;
   logic        lte_hit;
   logic [21:0] n;

   assign n       = in_data.channel_number;
   assign lte_hit = |in_data.hit;

   always_comb begin
      row = '0;
      for (int i = 0; i < LTE_ROWS; i++) begin
         row = row | (in_data.hit[i] ? LTE_TAB[i] : '0);
      end
   end

   always_comb begin
      data_in = '0;
      unique case (in_data.cmd)
         CMD_LTE: begin
            if (lte_hit) begin
               data_in.offset = n - {5'b0, row.lo};
               data_in.step   = STEP_LTE;
               data_in.base   = {7'b0, row.edge_khz};
               data_in.band   = row.band;
               data_in.ok     = 1'b1;
            end
         end
         CMD_NR: begin
            priority if (n <= NR_LAST_LOW) begin
               data_in.offset = n;
               data_in.step   = STEP_NR_LOW;
               data_in.ok     = 1'b1;
            end else if (n <= NR_LAST_MID) begin
               data_in.offset = n - NR_FIRST_MID;
               data_in.step   = STEP_NR_MID;
               data_in.base   = NR_BASE_MID;
               data_in.ok     = 1'b1;
            end else if (n <= NR_LAST_HIGH) begin
               data_in.offset = n - NR_FIRST_HIGH;
               data_in.step   = STEP_NR_HIGH;
               data_in.base   = NR_BASE_HIGH;
               data_in.ok     = 1'b1;
            end else begin
               data_in.ok     = 1'b0;
            end
         end
         CMD_WCDMA: begin
            data_in.offset = n;
            data_in.step   = STEP_WCDMA;
            data_in.ok     = 1'b1;
         end
         default: begin
            data_in = '0;
         end
      endcase
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/aftb_scale.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aftb_scale (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire aftb_pkg::sel_type  in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output aftb_pkg::rsp_type       out_data
);
   import aftb_pkg::*;

   logic        mul_valid_ff;
   logic        mul_ready;
   logic [29:0] product_ff;
   logic [29:0] product_in;
   logic [29:0] base_ff;
   logic [6:0]  band_ff;
   logic        ok_ff;

   logic        sum_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;

   assign product_in = {8'b0, in_data.offset} * {22'b0, in_data.step};

   assign in_ready  = !mul_valid_ff || mul_ready;
   assign mul_ready = !sum_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (in_ready) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         product_ff <= product_in;
         base_ff    <= in_data.base;
         band_ff    <= in_data.band;
         ok_ff      <= in_data.ok;
      end
   end

   always_comb begin
      rsp_in.carrier_khz = base_ff + product_ff;
      rsp_in.band_number = band_ff;
      rsp_in.converted   = ok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         sum_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_valid_ff && mul_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign out_data  = rsp_ff;

endmodule

`default_nettype wire
